### hw/rtl/ctks_pkg.sv
// ----------------------------------------------------------------------------
// Camera trajectory Kalman smoother: shared package
// Widths, reset values, datapath commands, controller states and the
// saturation helpers used by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package ctks_pkg;

    // Fixed-point format and accumulator width.
    localparam int FRAC_BITS = 16;
    localparam int SUM_WIDTH = 48;

    // Field widths.
    localparam int DELTA_W = 32;
    localparam int ANGLE_W = 19;
    localparam int OUT_W   = 32;
    localparam int VAR_W   = 32;
    localparam int Q_W     = 16;
    localparam int R_W     = 24;

    // Gain computation widths.
    localparam int PP_W      = VAR_W + 1;
    localparam int DEN_W     = PP_W + 1;
    localparam int REM_W     = DEN_W + 1;
    localparam int K_W       = FRAC_BITS + 1;
    localparam int DIV_STEPS = K_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Blend multiply widths: the difference is split into a low word and a high part.
    localparam int MAG_W    = SUM_WIDTH + 1;
    localparam int LO_W     = 32;
    localparam int HI_W     = MAG_W - LO_W;
    localparam int MUL_A_W  = PP_W;
    localparam int PROD_W   = MUL_A_W + K_W;
    localparam int HI_SHIFT = LO_W - FRAC_BITS;
    localparam int VAR_P_W  = PROD_W - FRAC_BITS;

    // Axes.
    localparam int AXES   = 3;
    localparam int AXIS_W = 2;

    // Stream packing.
    localparam int DX_LSB      = 0;
    localparam int DY_LSB      = DELTA_W;
    localparam int DA_LSB      = 2 * DELTA_W;
    localparam int IN_FIELDS_W = 2 * DELTA_W + ANGLE_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = AXES * OUT_W;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Constants and reset values.
    localparam logic [K_W-1:0]   K_ONE     = K_W'(1) << FRAC_BITS;
    localparam logic [VAR_W-1:0] VAR_RESET = VAR_W'(1) << FRAC_BITS;
    localparam logic [Q_W-1:0]   Q_RESET   = Q_W'(262);
    localparam logic [R_W-1:0]   R_RESET   = R_W'(16384);
    localparam logic             REG_IDX_Q = 1'b0;
    localparam logic             REG_IDX_R = 1'b1;

    typedef logic signed [SUM_WIDTH-1:0] sum_t;
    typedef logic signed [DELTA_W-1:0]   delta_t;
    typedef logic signed [OUT_W-1:0]     out_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MAG,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_SCALE_SUM,
        OP_EST,
        OP_MUL_VAR,
        OP_VAR,
        OP_ERR,
        OP_OUT
    } dp_op_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_INIT,
        S_DIV,
        S_MAG,
        S_MUL_LO,
        S_MUL_HI,
        S_SCALE_SUM,
        S_EST,
        S_VAR_MUL,
        S_VAR,
        S_ERR,
        S_OUT
    } state_t;

    typedef struct packed {
        dp_op_t            op;
        logic              first;
        logic [AXIS_W-1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic out_stall;
    } status_t;

    // Clamp a sum that grew by one bit to the signed accumulator range.
    function automatic sum_t sat_sum(input logic signed [SUM_WIDTH:0] v);
        sum_t r;
        if (v[SUM_WIDTH] != v[SUM_WIDTH-1])
        begin
            r = v[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end
        else
        begin
            r = v[SUM_WIDTH-1:0];
        end
        return r;
    endfunction

    // Clamp a correction value to the signed output range.
    function automatic out_t sat_out(input logic signed [SUM_WIDTH+1:0] v);
        logic [SUM_WIDTH+2-OUT_W:0] up;
        out_t r;
        up = v[SUM_WIDTH+1:OUT_W-1];
        if ((&up) || !(|up))
        begin
            r = v[OUT_W-1:0];
        end
        else
        begin
            r = v[SUM_WIDTH+1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

### hw/rtl/ctks_ctrl.sv
// ----------------------------------------------------------------------------
// Camera trajectory Kalman smoother: controller
// Sequences one beat through load, gain division, per-axis blend, variance update and output
// (the first beat: load, error, output), issuing one datapath operation per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module ctks_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output ctks_pkg::cmd_t     cmd,
    input  ctks_pkg::status_t  status
);

    ctks_pkg::state_t                state_reg, state_next;
    logic [ctks_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ctks_pkg::AXIS_W-1:0]     axis_reg, axis_next;
    logic                            first_reg, first_next;

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctks_pkg::S_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
            first_reg <= first_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        first_next = first_reg;
        in_ready   = 1'b0;
        cmd.op     = ctks_pkg::OP_NONE;
        cmd.first  = first_reg;
        cmd.axis   = axis_reg;

        unique case (state_reg)
            ctks_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = ctks_pkg::OP_LOAD;
                    first_next = 1'b0;
                    state_next = first_reg ? ctks_pkg::S_ERR : ctks_pkg::S_DIV_INIT;
                end
            end
            ctks_pkg::S_DIV_INIT:
            begin
                cmd.op     = ctks_pkg::OP_DIV_INIT;
                cnt_next   = ctks_pkg::CNT_W'(ctks_pkg::DIV_STEPS - 1);
                state_next = ctks_pkg::S_DIV;
            end
            ctks_pkg::S_DIV:
            begin
                cmd.op = ctks_pkg::OP_DIV_STEP;
                if (cnt_reg == '0)
                begin
                    axis_next  = '0;
                    state_next = ctks_pkg::S_MAG;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ctks_pkg::S_MAG:
            begin
                cmd.op     = ctks_pkg::OP_MAG;
                state_next = ctks_pkg::S_MUL_LO;
            end
            ctks_pkg::S_MUL_LO:
            begin
                cmd.op     = ctks_pkg::OP_MUL_LO;
                state_next = ctks_pkg::S_MUL_HI;
            end
            ctks_pkg::S_MUL_HI:
            begin
                cmd.op     = ctks_pkg::OP_MUL_HI;
                state_next = ctks_pkg::S_SCALE_SUM;
            end
            ctks_pkg::S_SCALE_SUM:
            begin
                cmd.op     = ctks_pkg::OP_SCALE_SUM;
                state_next = ctks_pkg::S_EST;
            end
            ctks_pkg::S_EST:
            begin
                cmd.op = ctks_pkg::OP_EST;
                if (axis_reg == ctks_pkg::AXIS_W'(ctks_pkg::AXES - 1))
                begin
                    state_next = ctks_pkg::S_VAR_MUL;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ctks_pkg::S_MAG;
                end
            end
            ctks_pkg::S_VAR_MUL:
            begin
                cmd.op     = ctks_pkg::OP_MUL_VAR;
                state_next = ctks_pkg::S_VAR;
            end
            ctks_pkg::S_VAR:
            begin
                cmd.op     = ctks_pkg::OP_VAR;
                state_next = ctks_pkg::S_ERR;
            end
            ctks_pkg::S_ERR:
            begin
                cmd.op     = ctks_pkg::OP_ERR;
                state_next = ctks_pkg::S_OUT;
            end
            ctks_pkg::S_OUT:
            begin
                // Wait for the output register to free up.
                if (!status.out_stall)
                begin
                    cmd.op     = ctks_pkg::OP_OUT;
                    state_next = ctks_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ctks_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/ctks_dpath.sv
// ----------------------------------------------------------------------------
// Camera trajectory Kalman smoother: datapath
// Holds the trajectory, estimate, variance and last good motion, a serial
// restoring divider for the gain, one shared multiplier and the output register.
// ----------------------------------------------------------------------------
module ctks_dpath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ctks_pkg::cmd_t                       cmd,
    output ctks_pkg::status_t                    status,
    input  logic [ctks_pkg::IN_TDATA_W-1:0]      in_data,
    input  logic                                 in_found,
    input  logic [ctks_pkg::Q_W-1:0]             q_noise,
    input  logic [ctks_pkg::R_W-1:0]             r_noise,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ctks_pkg::OUT_TDATA_W-1:0]     out_data
);

    // Filter state.
    ctks_pkg::sum_t   traj_reg [ctks_pkg::AXES];
    ctks_pkg::sum_t   traj_next [ctks_pkg::AXES];
    ctks_pkg::sum_t   est_reg [ctks_pkg::AXES];
    ctks_pkg::sum_t   est_next [ctks_pkg::AXES];
    ctks_pkg::delta_t good_reg [ctks_pkg::AXES];
    ctks_pkg::delta_t good_next [ctks_pkg::AXES];
    logic [ctks_pkg::VAR_W-1:0] var_reg, var_next;

    // Working registers.
    ctks_pkg::delta_t                  d_reg [ctks_pkg::AXES];
    ctks_pkg::delta_t                  d_next [ctks_pkg::AXES];
    logic signed [ctks_pkg::SUM_WIDTH:0] err_reg [ctks_pkg::AXES];
    logic signed [ctks_pkg::SUM_WIDTH:0] err_next [ctks_pkg::AXES];
    ctks_pkg::out_t                    res_reg [ctks_pkg::AXES];
    ctks_pkg::out_t                    res_next [ctks_pkg::AXES];
    logic [ctks_pkg::PP_W-1:0]         pp_reg, pp_next;
    logic [ctks_pkg::DEN_W-1:0]        den_reg, den_next;
    logic [ctks_pkg::REM_W-1:0]        rem_reg, rem_next;
    logic [ctks_pkg::K_W-1:0]          quo_reg, quo_next;
    logic [ctks_pkg::MAG_W-1:0]        mag_reg, mag_next;
    logic                              dir_reg, dir_next;
    logic [ctks_pkg::MAG_W-1:0]        scaled_reg, scaled_next;
    logic [ctks_pkg::PROD_W-1:0]       prod_reg, prod_next;
    logic                              out_valid_reg, out_valid_next;

    // Shared multiplier and gain.
    logic [ctks_pkg::MUL_A_W-1:0] mul_a;
    logic [ctks_pkg::K_W-1:0]     mul_b;
    logic [ctks_pkg::PROD_W-1:0]  mul_p;
    logic [ctks_pkg::K_W-1:0]     k_val;
    ctks_pkg::delta_t             d_in [ctks_pkg::AXES];

    assign k_val = (den_reg == '0) ? '0 : quo_reg;

    // Sign-extended input fields.
    assign d_in[0] = in_data[ctks_pkg::DX_LSB +: ctks_pkg::DELTA_W];
    assign d_in[1] = in_data[ctks_pkg::DY_LSB +: ctks_pkg::DELTA_W];
    assign d_in[2] = {{(ctks_pkg::DELTA_W - ctks_pkg::ANGLE_W)
                       {in_data[ctks_pkg::DA_LSB + ctks_pkg::ANGLE_W - 1]}},
                      in_data[ctks_pkg::DA_LSB +: ctks_pkg::ANGLE_W]};

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = ctks_pkg::MUL_A_W'(mag_reg[ctks_pkg::LO_W-1:0]);
        mul_b = k_val;
        if (cmd.op == ctks_pkg::OP_MUL_HI)
        begin
            mul_a = ctks_pkg::MUL_A_W'(mag_reg[ctks_pkg::MAG_W-1:ctks_pkg::LO_W]);
        end
        else if (cmd.op == ctks_pkg::OP_MUL_VAR)
        begin
            mul_a = pp_reg;
            mul_b = ctks_pkg::K_ONE - k_val;
        end
    end

    assign mul_p = mul_a * mul_b;

    // Next-value logic for every datapath operation.
    always_comb
    begin
        ctks_pkg::delta_t                    d_sel;
        logic signed [ctks_pkg::SUM_WIDTH:0]   tsum;
        logic signed [ctks_pkg::MAG_W-1:0]     t_x;
        logic signed [ctks_pkg::MAG_W-1:0]     e_x;
        logic [ctks_pkg::REM_W-1:0]            rem_sub;
        logic                                  rem_ge;
        logic [ctks_pkg::PP_W-1:0]             pp_w;
        logic [ctks_pkg::PROD_W+ctks_pkg::HI_SHIFT-1:0] hi_part;
        logic [ctks_pkg::VAR_P_W-1:0]          p_full;
        logic signed [ctks_pkg::SUM_WIDTH+1:0] corr;

        traj_next      = traj_reg;
        est_next       = est_reg;
        good_next      = good_reg;
        var_next       = var_reg;
        d_next         = d_reg;
        err_next       = err_reg;
        res_next       = res_reg;
        pp_next        = pp_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        mag_next       = mag_reg;
        dir_next       = dir_reg;
        scaled_next    = scaled_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !out_ready;

        d_sel   = '0;
        tsum    = '0;
        t_x     = '0;
        e_x     = '0;
        rem_sub = '0;
        rem_ge  = 1'b0;
        pp_w    = '0;
        hi_part = '0;
        p_full  = '0;
        corr    = '0;

        unique case (cmd.op)
            ctks_pkg::OP_LOAD:
            begin
                // Pick the motion and add it into each trajectory.
                for (int i = 0; i < ctks_pkg::AXES; i++)
                begin
                    d_sel = in_found ? d_in[i] : good_reg[i];
                    d_next[i] = d_sel;
                    good_next[i] = d_sel;
                    tsum = {traj_reg[i][ctks_pkg::SUM_WIDTH-1], traj_reg[i]}
                         + {{(ctks_pkg::SUM_WIDTH + 1 - ctks_pkg::DELTA_W)
                             {d_sel[ctks_pkg::DELTA_W-1]}}, d_sel};
                    traj_next[i] = ctks_pkg::sat_sum(tsum);
                    if (cmd.first)
                    begin
                        est_next[i] = '0;
                    end
                end
                if (cmd.first)
                begin
                    var_next = ctks_pkg::VAR_RESET;
                end
            end
            ctks_pkg::OP_DIV_INIT:
            begin
                pp_w     = {1'b0, var_reg} + ctks_pkg::PP_W'(q_noise);
                pp_next  = pp_w;
                den_next = {1'b0, pp_w} + ctks_pkg::DEN_W'(r_noise);
                rem_next = ctks_pkg::REM_W'(pp_w);
                quo_next = '0;
            end
            ctks_pkg::OP_DIV_STEP:
            begin
                // One restoring step: one quotient bit per cycle.
                rem_ge   = rem_reg >= {1'b0, den_reg};
                rem_sub  = rem_ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
                rem_next = {rem_sub[ctks_pkg::REM_W-2:0], 1'b0};
                quo_next = {quo_reg[ctks_pkg::K_W-2:0], rem_ge};
            end
            ctks_pkg::OP_MAG:
            begin
                // Distance between trajectory and estimate, and its direction.
                t_x = {traj_reg[cmd.axis][ctks_pkg::SUM_WIDTH-1], traj_reg[cmd.axis]};
                e_x = {est_reg[cmd.axis][ctks_pkg::SUM_WIDTH-1], est_reg[cmd.axis]};
                dir_next = t_x >= e_x;
                mag_next = (t_x >= e_x) ? (t_x - e_x) : (e_x - t_x);
            end
            ctks_pkg::OP_MUL_LO:
            begin
                prod_next = mul_p;
            end
            ctks_pkg::OP_MUL_HI:
            begin
                scaled_next = ctks_pkg::MAG_W'(prod_reg >> ctks_pkg::FRAC_BITS);
                prod_next   = mul_p;
            end
            ctks_pkg::OP_SCALE_SUM:
            begin
                hi_part     = {prod_reg, {ctks_pkg::HI_SHIFT{1'b0}}};
                scaled_next = scaled_reg + hi_part[ctks_pkg::MAG_W-1:0];
            end
            ctks_pkg::OP_EST:
            begin
                // The step never overshoots the trajectory, so it stays in range.
                if (dir_reg)
                begin
                    est_next[cmd.axis] = est_reg[cmd.axis]
                                       + scaled_reg[ctks_pkg::SUM_WIDTH-1:0];
                end
                else
                begin
                    est_next[cmd.axis] = est_reg[cmd.axis]
                                       - scaled_reg[ctks_pkg::SUM_WIDTH-1:0];
                end
            end
            ctks_pkg::OP_MUL_VAR:
            begin
                prod_next = mul_p;
            end
            ctks_pkg::OP_VAR:
            begin
                p_full = prod_reg[ctks_pkg::PROD_W-1:ctks_pkg::FRAC_BITS];
                if (|p_full[ctks_pkg::VAR_P_W-1:ctks_pkg::VAR_W])
                begin
                    var_next = '1;
                end
                else
                begin
                    var_next = p_full[ctks_pkg::VAR_W-1:0];
                end
            end
            ctks_pkg::OP_ERR:
            begin
                for (int i = 0; i < ctks_pkg::AXES; i++)
                begin
                    err_next[i] = {est_reg[i][ctks_pkg::SUM_WIDTH-1], est_reg[i]}
                                - {traj_reg[i][ctks_pkg::SUM_WIDTH-1], traj_reg[i]};
                end
            end
            ctks_pkg::OP_OUT:
            begin
                for (int i = 0; i < ctks_pkg::AXES; i++)
                begin
                    corr = {err_reg[i][ctks_pkg::SUM_WIDTH], err_reg[i]}
                         + {{(ctks_pkg::SUM_WIDTH + 2 - ctks_pkg::DELTA_W)
                             {d_reg[i][ctks_pkg::DELTA_W-1]}}, d_reg[i]};
                    res_next[i] = ctks_pkg::sat_out(corr);
                end
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // State registers with reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ctks_pkg::AXES; i++)
            begin
                traj_reg[i] <= '0;
                est_reg[i]  <= '0;
                good_reg[i] <= '0;
            end
            var_reg       <= ctks_pkg::VAR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            traj_reg      <= traj_next;
            est_reg       <= est_next;
            good_reg      <= good_next;
            var_reg       <= var_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers, no reset needed.
    always_ff @(posedge clk)
    begin
        d_reg      <= d_next;
        err_reg    <= err_next;
        res_reg    <= res_next;
        pp_reg     <= pp_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        mag_reg    <= mag_next;
        dir_reg    <= dir_next;
        scaled_reg <= scaled_next;
        prod_reg   <= prod_next;
    end

    assign out_valid        = out_valid_reg;
    assign status.out_stall = out_valid_reg && !out_ready;
    assign out_data         = {res_reg[2], res_reg[1], res_reg[0]};

endmodule

### hw/rtl/camera_trajectory_kalman_smoother.sv
// ----------------------------------------------------------------------------
// Camera trajectory Kalman smoother: top level
// Each beat runs to the output register before the next is taken; the 17-step
// serial gain divider and the blend per axis (magnitude, low and high multiply,
// scale sum, estimate) on one shared multiplier set the pace. The first beat
// after reset skips the division, the blend and the variance update.
// A new beat is taken while the previous output beat still waits.
// Reset (rst_n low, asynchronous) clears trajectory, estimate and last motion,
// sets the variance to one and the noise registers to their defaults.
// ----------------------------------------------------------------------------
module camera_trajectory_kalman_smoother (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // delta_x [31:0], delta_y [63:32], delta_angle [82:64], zero pad [87:83]
    input  logic [ctks_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // transform_found [0]
    input  logic                                s_axis_tuser,
    // Output stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // corrected_dx [31:0], corrected_dy [63:32], corrected_angle [95:64]
    output logic [ctks_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ctks_pkg::APB_AW-1:0]         paddr,
    input  logic [ctks_pkg::APB_DW-1:0]         pwdata,
    output logic [ctks_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    ctks_pkg::cmd_t             cmd;
    ctks_pkg::status_t          dp_status;
    logic [ctks_pkg::Q_W-1:0]   q_reg, q_next;
    logic [ctks_pkg::R_W-1:0]   r_reg, r_next;
    logic                       cfg_write;

    // Noise registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                ctks_pkg::REG_IDX_Q: q_next = pwdata[ctks_pkg::Q_W-1:0];
                ctks_pkg::REG_IDX_R: r_next = pwdata[ctks_pkg::R_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= ctks_pkg::Q_RESET;
            r_reg <= ctks_pkg::R_RESET;
        end
        else
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (paddr[2])
            ctks_pkg::REG_IDX_Q: prdata = ctks_pkg::APB_DW'(q_reg);
            ctks_pkg::REG_IDX_R: prdata = ctks_pkg::APB_DW'(r_reg);
            default:             prdata = '0;
        endcase
    end

    // Controller.
    ctks_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .status   (dp_status)
    );

    // Datapath.
    ctks_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (dp_status),
        .in_data   (s_axis_tdata),
        .in_found  (s_axis_tuser),
        .q_noise   (q_reg),
        .r_noise   (r_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // A beat is loaded only when it is really accepted on the input port.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ctks_pkg::OP_LOAD) |-> (s_axis_tvalid && s_axis_tready))
    else $error("datapath load without an accepted input beat");

    // After an accepted beat the block is not ready again in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted again right after a beat");

    // A new result never overwrites an output beat that is still stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ctks_pkg::OP_OUT) |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("output register overwritten while stalled");

endmodule

### bench/tb_camera_trajectory_kalman_smoother.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the camera trajectory Kalman smoother
// Streams frame motions into the block and predicts every corrected motion
// with an independent fixed-point smoother. The noise registers are
// rewritten between phases while the block is idle. Both stream sides idle
// at random, and one long output stall backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_camera_trajectory_kalman_smoother;

    localparam int          ANG_MAX      = 205887;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          PHASE_ITEMS  = 260;

    localparam logic [ctks_pkg::APB_AW-1:0] ADDR_Q =
        ctks_pkg::APB_AW'(4 * ctks_pkg::REG_IDX_Q);
    localparam logic [ctks_pkg::APB_AW-1:0] ADDR_R =
        ctks_pkg::APB_AW'(4 * ctks_pkg::REG_IDX_R);

    localparam logic signed [ctks_pkg::DELTA_W-1:0] DELTA_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ctks_pkg::DELTA_W-1:0] DELTA_MIN = 32'sh8000_0000;

    localparam longint      SUM_HI = (longint'(1) << (ctks_pkg::SUM_WIDTH - 1)) - 1;
    localparam longint      SUM_LO = -SUM_HI - 1;
    localparam longint      OUT_HI = 64'sd2147483647;
    localparam longint      OUT_LO = -64'sd2147483648;
    localparam logic [63:0] ONE_Q  = 64'd1 << ctks_pkg::FRAC_BITS;

    // One frame motion as it travels on the input stream.
    typedef struct packed {
        logic                                found;
        logic signed [ctks_pkg::ANGLE_W-1:0] da;
        logic signed [ctks_pkg::DELTA_W-1:0] dy;
        logic signed [ctks_pkg::DELTA_W-1:0] dx;
    } motion_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [ctks_pkg::IN_TDATA_W-1:0]     s_axis_tdata = '0;
    logic                                s_axis_tuser = 1'b0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [ctks_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [ctks_pkg::APB_AW-1:0]         paddr = '0;
    logic [ctks_pkg::APB_DW-1:0]         pwdata = '0;
    logic [ctks_pkg::APB_DW-1:0]         prdata;
    logic                                pready;

    // Smoother state as predicted by the bench.
    longint                              path_sum [ctks_pkg::AXES];
    longint                              path_est [ctks_pkg::AXES];
    longint                              held_motion [ctks_pkg::AXES];
    logic [ctks_pkg::VAR_W-1:0]          err_var;
    logic                                first_pending;
    logic [ctks_pkg::Q_W-1:0]            q_noise;
    logic [ctks_pkg::R_W-1:0]            r_noise;

    motion_t                             motion_q [$];
    logic [ctks_pkg::OUT_TDATA_W-1:0]    shift_due [$];
    motion_t                             cur_motion;
    int                                  src_gap = 0;
    int                                  sink_gap = 0;
    int                                  hold_cnt = 0;
    logic                                hold_done = 1'b0;
    logic                                hold_phase = 1'b0;
    logic                                calm = 1'b0;
    int                                  err_count = 0;
    int unsigned                         cycle_count = 0;
    string                               axis_name [ctks_pkg::AXES] =
        '{"corrected_dx", "corrected_dy", "corrected_angle"};

    camera_trajectory_kalman_smoother u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Global watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Append one motion to the pending queue.
    task automatic add_motion(input motion_t m);
        motion_q = {motion_q, m};
    endtask

    // Advance the predicted smoother by one accepted motion and return the
    // corrected shifts packed as on the output stream.
    task automatic smooth_step(input motion_t m,
                               output logic [ctks_pkg::OUT_TDATA_W-1:0] shifts);
        longint      d [ctks_pkg::AXES];
        longint      acc;
        longint      xs;
        longint      zs;
        longint      e;
        logic [63:0] pp;
        logic [63:0] den;
        logic [63:0] gain;
        logic [63:0] mag;
        logic [63:0] pn;
        logic [79:0] prod;
        int          i;
        // A missing motion repeats the last good one.
        if (m.found)
        begin
            held_motion[0] = m.dx;
            held_motion[1] = m.dy;
            held_motion[2] = m.da;
        end
        // Accumulate the trajectory, clamped to the accumulator range.
        for (i = 0; i < ctks_pkg::AXES; i++)
        begin
            d[i] = held_motion[i];
            acc = path_sum[i] + d[i];
            if (acc > SUM_HI)
            begin
                acc = SUM_HI;
            end
            else if (acc < SUM_LO)
            begin
                acc = SUM_LO;
            end
            path_sum[i] = acc;
        end
        if (first_pending)
        begin
            first_pending = 1'b0;
            for (i = 0; i < ctks_pkg::AXES; i++)
            begin
                path_est[i] = 0;
            end
            err_var = ctks_pkg::VAR_RESET;
        end
        else
        begin
            // Shared gain; a zero denominator leaves the estimate alone.
            pp = 64'(err_var) + 64'(q_noise);
            den = pp + 64'(r_noise);
            gain = (den == 64'd0) ? 64'd0 : (pp << ctks_pkg::FRAC_BITS) / den;
            if (gain > ONE_Q)
            begin
                gain = ONE_Q;
            end
            // Move each estimate toward its trajectory, truncating toward zero.
            for (i = 0; i < ctks_pkg::AXES; i++)
            begin
                xs = path_est[i];
                zs = path_sum[i];
                if (zs >= xs)
                begin
                    mag = zs - xs;
                    prod = 80'(mag) * 80'(gain);
                    path_est[i] = xs + longint'(prod >> ctks_pkg::FRAC_BITS);
                end
                else
                begin
                    mag = xs - zs;
                    prod = 80'(mag) * 80'(gain);
                    path_est[i] = xs - longint'(prod >> ctks_pkg::FRAC_BITS);
                end
            end
            pn = ((ONE_Q - gain) * pp) >> ctks_pkg::FRAC_BITS;
            err_var = (pn > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pn[ctks_pkg::VAR_W-1:0];
        end
        // Correction, saturated to the output range.
        for (i = 0; i < ctks_pkg::AXES; i++)
        begin
            e = path_est[i] - path_sum[i] + d[i];
            if (e > OUT_HI)
            begin
                e = OUT_HI;
            end
            else if (e < OUT_LO)
            begin
                e = OUT_LO;
            end
            shifts[i*ctks_pkg::OUT_W +: ctks_pkg::OUT_W] = e[ctks_pkg::OUT_W-1:0];
        end
    endtask

    function automatic motion_t mk_motion(input logic found,
                                          input logic signed [ctks_pkg::DELTA_W-1:0] dx,
                                          input logic signed [ctks_pkg::DELTA_W-1:0] dy,
                                          input logic signed [ctks_pkg::ANGLE_W-1:0] da);
        motion_t m;
        m.found = found;
        m.dx = dx;
        m.dy = dy;
        m.da = da;
        return m;
    endfunction

    // Mostly small camera shake, with full-range and extreme frames mixed in.
    function automatic motion_t rand_motion();
        motion_t m;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                m.dx = $urandom;
                m.dy = $urandom;
            end
            2:
            begin
                m.dx = $urandom_range(0, 1) ? DELTA_MAX : DELTA_MIN;
                m.dy = $urandom_range(0, 1) ? DELTA_MAX : DELTA_MIN;
            end
            default:
            begin
                m.dx = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
                m.dy = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            end
        endcase
        case ($urandom_range(0, 5))
            0: m.da = $urandom_range(0, 1) ? ctks_pkg::ANGLE_W'(ANG_MAX)
                                           : ctks_pkg::ANGLE_W'(-ANG_MAX);
            1, 2: m.da = ctks_pkg::ANGLE_W'($urandom_range(0, 2 * ANG_MAX) - ANG_MAX);
            default: m.da = ctks_pkg::ANGLE_W'($urandom_range(0, 8192) - 4096);
        endcase
        m.found = ($urandom_range(0, 6) != 0);
        return m;
    endfunction

    // Register write: setup cycle, then access cycle.
    task automatic apb_write(input logic [ctks_pkg::APB_AW-1:0] addr,
                             input logic [ctks_pkg::APB_DW-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_Q)
        begin
            q_noise = data[ctks_pkg::Q_W-1:0];
        end
        else if (addr == ADDR_R)
        begin
            r_noise = data[ctks_pkg::R_W-1:0];
        end
    endtask

    // Wait until every motion is sent and every shift has come back.
    task automatic wait_drained();
        while (motion_q.size() != 0 || s_axis_tvalid || shift_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Reconfigure while idle, then queue a run of random frames.
    task automatic run_phase(input logic [ctks_pkg::Q_W-1:0] q,
                             input logic [ctks_pkg::R_W-1:0] r,
                             input int count, input logic hold, input logic quiet);
        int n;
        wait_drained();
        apb_write(ADDR_Q, (32'($urandom) & ~32'h0000_FFFF) | 32'(q));
        apb_write(ADDR_R, (32'($urandom) & ~32'h00FF_FFFF) | 32'(r));
        @(negedge clk);
        calm = quiet;
        hold_phase = hold;
        for (n = 0; n < count; n++)
        begin
            add_motion(rand_motion());
        end
    endtask

    // Input driver: offers queued motions with random bursts of idle cycles.
    always @(posedge clk or negedge rst_n)
    begin : feed
        motion_t                          nxt;
        logic                             take;
        logic [ctks_pkg::OUT_TDATA_W-1:0] shifts;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
            src_gap <= 0;
        end
        else
        begin
            take = s_axis_tvalid && s_axis_tready;
            if (take)
            begin
                smooth_step(cur_motion, shifts);
                shift_due = {shift_due, shifts};
            end
            if (!s_axis_tvalid || take)
            begin
                if (src_gap != 0)
                begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (motion_q.size() != 0 && !calm && $urandom_range(0, 7) == 0)
                begin
                    src_gap <= $urandom_range(0, 2);
                    s_axis_tvalid <= 1'b0;
                end
                else if (motion_q.size() != 0)
                begin
                    nxt = motion_q.pop_front();
                    cur_motion <= nxt;
                    s_axis_tdata <= {{(ctks_pkg::IN_TDATA_W - ctks_pkg::IN_FIELDS_W){1'b0}},
                                     nxt.da, nxt.dy, nxt.dx};
                    s_axis_tuser <= nxt.found;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output ready: random short stalls, plus one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin : sink
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap <= 0;
            hold_cnt <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_phase && !hold_done)
        begin
            hold_cnt <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_axis_tready <= 1'b0;
        end
        else if (sink_gap != 0)
        begin
            sink_gap <= sink_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            sink_gap <= $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Output monitor: each beat against the oldest predicted shifts.
    always @(posedge clk)
    begin : watch
        logic [ctks_pkg::OUT_TDATA_W-1:0] want;
        int                               i;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (shift_due.size() == 0)
            begin
                report_error($sformatf("output beat %h with nothing expected", m_axis_tdata));
            end
            else
            begin
                want = shift_due.pop_front();
                for (i = 0; i < ctks_pkg::AXES; i++)
                begin
                    if (m_axis_tdata[i*ctks_pkg::OUT_W +: ctks_pkg::OUT_W]
                        !== want[i*ctks_pkg::OUT_W +: ctks_pkg::OUT_W])
                    begin
                        report_error($sformatf("%s got %0d expected %0d", axis_name[i],
                                     $signed(m_axis_tdata[i*ctks_pkg::OUT_W +: ctks_pkg::OUT_W]),
                                     $signed(want[i*ctks_pkg::OUT_W +: ctks_pkg::OUT_W])));
                    end
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        int i;
        for (i = 0; i < ctks_pkg::AXES; i++)
        begin
            path_sum[i] = 0;
            path_est[i] = 0;
            held_motion[i] = 0;
        end
        err_var = ctks_pkg::VAR_RESET;
        first_pending = 1'b1;
        q_noise = ctks_pkg::Q_RESET;
        r_noise = ctks_pkg::R_RESET;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Defaults rewritten with junk in the unused upper bits.
        apb_write(ADDR_Q, 32'hA5A5_0000 | 32'(ctks_pkg::Q_RESET));
        apb_write(ADDR_R, 32'h5A00_0000 | 32'(ctks_pkg::R_RESET));
        @(negedge clk);

        // Directed frames. The first one is missing before any valid motion.
        add_motion(mk_motion(1'b0, 32'sd12345, -32'sd999, 19'sd77));
        add_motion(mk_motion(1'b1, DELTA_MAX, DELTA_MIN, ctks_pkg::ANGLE_W'(ANG_MAX)));
        add_motion(mk_motion(1'b1, DELTA_MIN, DELTA_MAX, ctks_pkg::ANGLE_W'(-ANG_MAX)));
        add_motion(mk_motion(1'b1, 32'sd0, 32'sd0, 19'sd0));
        add_motion(mk_motion(1'b0, DELTA_MAX, DELTA_MAX, ctks_pkg::ANGLE_W'(ANG_MAX)));
        add_motion(mk_motion(1'b1, 32'sd1, -32'sd1, 19'sd1));
        add_motion(mk_motion(1'b0, DELTA_MIN, DELTA_MIN, ctks_pkg::ANGLE_W'(-ANG_MAX)));
        // A run of extreme motion drives the outputs into saturation.
        for (i = 0; i < 6; i++)
        begin
            add_motion(mk_motion(1'b1, DELTA_MAX, DELTA_MIN, ctks_pkg::ANGLE_W'(ANG_MAX)));
        end
        add_motion(mk_motion(1'b0, 32'sd0, 32'sd0, 19'sd0));
        add_motion(mk_motion(1'b0, 32'sd0, 32'sd0, 19'sd0));
        add_motion(mk_motion(1'b1, 32'sh5555_5555, 32'shAAAA_AAAA, 19'sh2AAAA));
        add_motion(mk_motion(1'b1, 32'shAAAA_AAAA, 32'sh5555_5555, 19'sh55555));
        add_motion(mk_motion(1'b1, -32'sd1, -32'sd1, -19'sd1));
        add_motion(mk_motion(1'b1, DELTA_MIN, DELTA_MIN, ctks_pkg::ANGLE_W'(-ANG_MAX)));
        add_motion(mk_motion(1'b1, 32'sd65536, -32'sd65536, 19'sd6554));

        // Zero noise: the gain reaches one, then the denominator becomes zero.
        run_phase(16'd0, 24'd0, PHASE_ITEMS, 1'b1, 1'b0);
        // Largest noise values.
        run_phase(16'hFFFF, 24'hFF_FFFF, PHASE_ITEMS, 1'b0, 1'b0);
        run_phase(16'($urandom), 24'($urandom), PHASE_ITEMS, 1'b0, 1'b0);
        run_phase(16'($urandom_range(0, 1023)), 24'($urandom_range(0, 65535)),
                  PHASE_ITEMS, 1'b0, 1'b0);
        // Closing stretch with no idling on either side.
        run_phase(16'hFFFF, 24'd0, PHASE_ITEMS, 1'b0, 1'b1);

        wait_drained();
        if (err_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
